>>> rtl/tpi_pkg.sv
// ----------------------------------------------------------------------------
// tpi_pkg
// Shared widths and types for the three-plane intersection block.
// ----------------------------------------------------------------------------
package tpi_pkg;

    localparam int unsigned W_IN  = 32;
    localparam int unsigned W_C   = 65;   // cross product component
    localparam int unsigned W_ACC = 100;  // numerator / denominator, exact
    localparam int unsigned W_DIV = 116;  // |num| << 16
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR   = 2;

    // classified job from the front end
    typedef struct packed {
        logic                    found;
        logic                    neg_x;
        logic                    neg_y;
        logic                    neg_z;
        logic [W_DIV-1:0]        num_x;
        logic [W_DIV-1:0]        num_y;
        logic [W_DIV-1:0]        num_z;
        logic [W_ACC-1:0]        den;
    } t_job;

endpackage

>>> rtl/tpi_front.sv
// ----------------------------------------------------------------------------
// tpi_front
// Pipelined cross products, denominator and numerators; classifies each beat.
// Four register stages; one beat per cycle.
// ----------------------------------------------------------------------------
module tpi_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic signed [31:0]   i_n [9],
    input  logic signed [31:0]   i_w [3],
    output logic                 o_vld,
    output tpi_pkg::t_job        o_job
);
    import tpi_pkg::*;

    // stage 1: products for cross terms
    logic signed [63:0] r_p [18];
    logic signed [32:0] r_d1 [3];
    logic signed [31:0] r_a1 [3];
    // stage 2: cross products
    logic signed [W_C-1:0] r_c [9];
    logic signed [32:0] r_d2 [3];
    logic signed [31:0] r_a2 [3];
    // stage 3: d and n1 times the low and high halves of each cross term
    logic signed [65:0] r_ql [12];
    logic signed [65:0] r_qh [12];
    // stage 4: recombined products with d and n1
    logic signed [97:0] r_q [12];
    logic [3:0] r_v;

    // plane i normal component k = i_n[i*3+k]
    function automatic int idx(input int p, input int k);
        return p * 3 + k;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        // c_j = N(j+1) x N(j+2)
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                r_p[j*6+k*2]   <= i_n[idx((j+1)%3, (k+1)%3)] * i_n[idx((j+2)%3, (k+2)%3)];
                r_p[j*6+k*2+1] <= i_n[idx((j+1)%3, (k+2)%3)] * i_n[idx((j+2)%3, (k+1)%3)];
            end
            r_d1[j] <= -(33'(i_w[j]));
            r_a1[j] <= i_n[j];
        end
        for (int j = 0; j < 9; j++) begin
            r_c[j] <= W_C'(r_p[j*2]) - W_C'(r_p[j*2+1]);
        end
        r_d2 <= r_d1;
        r_a2 <= r_a1;
        // split each 65-bit cross term into an unsigned low word and a signed high part
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                r_ql[k*3+j] <= r_d2[j] * $signed({1'b0, r_c[j*3+k][31:0]});
                r_qh[k*3+j] <= r_d2[j] * $signed(r_c[j*3+k][W_C-1:32]);
            end
            r_ql[9+k] <= r_a2[k] * $signed({1'b0, r_c[k][31:0]});
            r_qh[9+k] <= r_a2[k] * $signed(r_c[k][W_C-1:32]);
        end
        for (int j = 0; j < 12; j++) begin
            r_q[j] <= {r_qh[j], 32'h0} + 98'(r_ql[j]);
        end
    end

    logic signed [W_ACC-1:0] num [3];
    logic signed [W_ACC-1:0] den;
    logic signed [W_ACC-1:0] anum [3];
    logic                    dneg;

    always_comb begin
        den = W_ACC'(r_q[9]) + W_ACC'(r_q[10]) + W_ACC'(r_q[11]);
        dneg = den[W_ACC-1];
        for (int k = 0; k < 3; k++) begin
            num[k] = W_ACC'(r_q[k*3]) + W_ACC'(r_q[k*3+1]) + W_ACC'(r_q[k*3+2]);
            anum[k] = num[k][W_ACC-1] ? -num[k] : num[k];
        end
        o_vld       = r_v[3];
        o_job.found = (den != '0);
        o_job.den   = dneg ? -den : den;
        o_job.neg_x = num[0][W_ACC-1] ^ dneg;
        o_job.neg_y = num[1][W_ACC-1] ^ dneg;
        o_job.neg_z = num[2][W_ACC-1] ^ dneg;
        o_job.num_x = {anum[0], 16'h0};
        o_job.num_y = {anum[1], 16'h0};
        o_job.num_z = {anum[2], 16'h0};
    end

endmodule

>>> rtl/tpi_queue.sv
// ----------------------------------------------------------------------------
// tpi_queue
// Small FIFO between front and back ends.
// ----------------------------------------------------------------------------
module tpi_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tpi_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [tpi_pkg::QPTR:0] o_count,
    output tpi_pkg::t_job o_job
);
    import tpi_pkg::*;

    t_job            r_mem [QDEPTH];
    logic [QPTR-1:0] r_wp, r_rp;
    logic [QPTR:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPTR+1)'(i_push) - (QPTR+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_job   = r_mem[r_rp];

endmodule

>>> rtl/tpi_back.sv
// ----------------------------------------------------------------------------
// tpi_back
// Restoring divider, one quotient bit per cycle for all three components,
// then sign and saturation.
// ----------------------------------------------------------------------------
module tpi_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  tpi_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_vld,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y,
    output logic signed [31:0] o_z,
    output logic               o_found
);
    import tpi_pkg::*;

    localparam logic [6:0] LAST = 7'(W_DIV - 1);

    logic              r_busy;
    logic [6:0]        r_cnt;
    t_job              r_job;
    logic [W_DIV-1:0]  r_rem [3];
    logic [W_DIV-1:0]  r_q [3];
    logic              r_vld;
    logic signed [31:0] r_o [3];
    logic              r_found;

    logic [W_DIV-1:0] n_rem [3];
    logic [W_DIV-1:0] n_q [3];
    logic [W_DIV-1:0] num [3];
    logic [W_DIV:0]   sh;
    logic [31:0]      sat [3];
    logic             neg [3];

    assign o_pop = !r_busy && !i_empty;

    always_comb begin
        num[0] = r_job.num_x; num[1] = r_job.num_y; num[2] = r_job.num_z;
        neg[0] = r_job.neg_x; neg[1] = r_job.neg_y; neg[2] = r_job.neg_z;
        sh = '0;
        for (int k = 0; k < 3; k++) begin
            sh = {r_rem[k], num[k][LAST - r_cnt]};
            if (sh >= {17'h0, r_job.den}) begin
                n_rem[k] = W_DIV'(sh - {17'h0, r_job.den});
                n_q[k]   = {r_q[k][W_DIV-2:0], 1'b1};
            end else begin
                n_rem[k] = W_DIV'(sh);
                n_q[k]   = {r_q[k][W_DIV-2:0], 1'b0};
            end
            if (neg[k]) begin
                sat[k] = (n_q[k] > W_DIV'(32'h8000_0000)) ? 32'h8000_0000
                                                          : 32'(-n_q[k]);
            end else begin
                sat[k] = (n_q[k] > W_DIV'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                          : n_q[k][31:0];
            end
            if (!r_job.found) sat[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_vld  <= 1'b0;
        end else begin
            r_vld <= r_busy && (r_cnt == LAST);
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_cnt <= '0;
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= '0;
                r_q[k]   <= '0;
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= n_rem;
            r_q   <= n_q;
            if (r_cnt == LAST) begin
                r_o     <= '{sat[0], sat[1], sat[2]};
                r_found <= r_job.found;
            end
        end
    end

    assign o_vld   = r_vld;
    assign o_x     = r_o[0];
    assign o_y     = r_o[1];
    assign o_z     = r_o[2];
    assign o_found = r_found;

endmodule

>>> rtl/three_plane_intersection_top.sv
// A beat passes the four front stages, waits in the queue until the back end pops
// it, is divided bit-serially and leaves through the output register.
// The shared bit-serial divider takes a new beat only once it is done with the last;
// up to three beats enter back to back before busy rises.
// Reset (synchronous, active low) empties the pipe and queue.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// three_plane_intersection_top
// Intersection point of three planes in Q16.16 with a found flag.
// ----------------------------------------------------------------------------
module three_plane_intersection_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_plane_a_nx,
    input  logic signed [31:0] i_plane_a_ny,
    input  logic signed [31:0] i_plane_a_nz,
    input  logic signed [31:0] i_plane_a_w,
    input  logic signed [31:0] i_plane_b_nx,
    input  logic signed [31:0] i_plane_b_ny,
    input  logic signed [31:0] i_plane_b_nz,
    input  logic signed [31:0] i_plane_b_w,
    input  logic signed [31:0] i_plane_c_nx,
    input  logic signed [31:0] i_plane_c_ny,
    input  logic signed [31:0] i_plane_c_nz,
    input  logic signed [31:0] i_plane_c_w,
    output logic               o_strobe,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z,
    output logic               o_found
);
    import tpi_pkg::*;

    logic        acc, f_vld, q_empty, q_pop;
    t_job        f_job, q_job;
    logic [QPTR:0] q_cnt;
    logic [3:0]  r_fly;
    logic signed [31:0] pl_n [9];
    logic signed [31:0] pl_w [3];

    assign acc = start && !busy;

    assign pl_n = '{i_plane_a_nx, i_plane_a_ny, i_plane_a_nz,
                    i_plane_b_nx, i_plane_b_ny, i_plane_b_nz,
                    i_plane_c_nx, i_plane_c_ny, i_plane_c_nz};
    assign pl_w = '{i_plane_a_w, i_plane_b_w, i_plane_c_w};

    // in-flight beats plus queued ones must fit in the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fly <= '0;
        else          r_fly <= {r_fly[2:0], acc};
    end
    assign busy = (q_cnt + (QPTR+1)'(r_fly[0]) + (QPTR+1)'(r_fly[1])
                   + (QPTR+1)'(r_fly[2]) + (QPTR+1)'(r_fly[3]))
                  >= (QPTR+1)'(QDEPTH - 1);

    tpi_front u_front (
        .i_clk, .i_rst_n, .i_vld(acc),
        .i_n(pl_n),
        .i_w(pl_w),
        .o_vld(f_vld), .o_job(f_job)
    );

    tpi_queue u_queue (
        .i_clk, .i_rst_n, .i_push(f_vld), .i_job(f_job), .i_pop(q_pop),
        .o_empty(q_empty), .o_count(q_cnt), .o_job(q_job)
    );

    tpi_back u_back (
        .i_clk, .i_rst_n, .i_empty(q_empty), .i_job(q_job), .o_pop(q_pop),
        .o_vld(o_strobe), .o_x(o_point_x), .o_y(o_point_y), .o_z(o_point_z),
        .o_found(o_found)
    );

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(f_vld && !q_pop && q_cnt == (QPTR+1)'(QDEPTH))) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty) else $error("queue underflow");
    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_found) |-> (o_point_x == 0 && o_point_y == 0 && o_point_z == 0))
        else $error("zero point expected");
`endif

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the three-plane intersection block against an exact wide-integer
// model of the point and found flag.
// Each accepted beat is solved in 256-bit signed arithmetic and queued; every
// strobed result is compared field by field with the oldest queued point.
// The stimulus is a directed set of edge cases followed by random plane
// triples: full-range, moderate, and deliberately degenerate.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1600;

    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic signed [31:0] w;
    } t_plane;

    typedef struct packed {
        t_plane a;
        t_plane b;
        t_plane c;
        logic   drain;      // wait for every result before this beat
    } t_triple;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               found;
    } t_point;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_plane drv_a, drv_b, drv_c;
    logic o_strobe;
    logic signed [31:0] o_point_x, o_point_y, o_point_z;
    logic o_found;

    t_triple pending_triples[$];
    t_point  expected_points[$];
    int      beats_sent;
    int      points_seen;
    int      misses_found;
    int      mismatches;
    int      total_beats;
    logic    took;
    logic    stim_done;

    three_plane_intersection_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_plane_a_nx(drv_a.nx),
        .i_plane_a_ny(drv_a.ny),
        .i_plane_a_nz(drv_a.nz),
        .i_plane_a_w (drv_a.w),
        .i_plane_b_nx(drv_b.nx),
        .i_plane_b_ny(drv_b.ny),
        .i_plane_b_nz(drv_b.nz),
        .i_plane_b_w (drv_b.w),
        .i_plane_c_nx(drv_c.nx),
        .i_plane_c_ny(drv_c.ny),
        .i_plane_c_nz(drv_c.nz),
        .i_plane_c_w (drv_c.w),
        .o_strobe    (o_strobe),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_point_z   (o_point_z),
        .o_found     (o_found)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] divide_clamp(logic signed [255:0] num,
                                                        logic signed [255:0] den);
        logic [255:0] un, ud, q;
        logic         neg;
        neg = (num < 0) != (den < 0);
        un  = (num < 0) ? -num : num;
        ud  = (den < 0) ? -den : den;
        q   = (un << 16) / ud;
        if (neg) begin
            if (q > 256'h8000_0000) return 32'sh8000_0000;
            return -q[31:0];
        end
        if (q > 256'h7FFF_FFFF) return 32'sh7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic t_point solve_point(t_plane a, t_plane b, t_plane c);
        logic signed [255:0] ax, ay, az, bx, by, bz, cx, cy, cz, da, db, dc;
        logic signed [255:0] c1x, c1y, c1z, c2x, c2y, c2z, c3x, c3y, c3z, den;
        t_point r;
        ax = 256'(a.nx); ay = 256'(a.ny); az = 256'(a.nz); da = 256'(a.w); da = -da;
        bx = 256'(b.nx); by = 256'(b.ny); bz = 256'(b.nz); db = 256'(b.w); db = -db;
        cx = 256'(c.nx); cy = 256'(c.ny); cz = 256'(c.nz); dc = 256'(c.w); dc = -dc;
        c1x = by * cz - bz * cy; c1y = bz * cx - bx * cz; c1z = bx * cy - by * cx;
        c2x = cy * az - cz * ay; c2y = cz * ax - cx * az; c2z = cx * ay - cy * ax;
        c3x = ay * bz - az * by; c3y = az * bx - ax * bz; c3z = ax * by - ay * bx;
        den = ax * c1x + ay * c1y + az * c1z;
        r = '0;
        if (den == 0) return r;
        r.x = divide_clamp(da * c1x + db * c2x + dc * c3x, den);
        r.y = divide_clamp(da * c1y + db * c2y + dc * c3y, den);
        r.z = divide_clamp(da * c1z + db * c2z + dc * c3z, den);
        r.found = 1'b1;
        return r;
    endfunction

    task automatic flag_mismatch(string field, logic signed [31:0] got,
                                 logic signed [31:0] want);
        $display("mismatch %s on point %0d: got %h want %h", field, points_seen, got, want);
        mismatches++;
    endtask

    // latch acceptance and check results on the rising edge
    always @(posedge i_clk) begin
        t_point want;
        took <= start && !busy;
        if (i_rst_n && start && !busy)
            expected_points.push_back(solve_point(drv_a, drv_b, drv_c));
        if (i_rst_n && o_strobe) begin
            if (expected_points.size() == 0) begin
                $display("unexpected result beat: %h %h %h %b",
                         o_point_x, o_point_y, o_point_z, o_found);
                mismatches++;
            end else begin
                want = expected_points.pop_front();
                if (o_point_x !== want.x) flag_mismatch("x", o_point_x, want.x);
                if (o_point_y !== want.y) flag_mismatch("y", o_point_y, want.y);
                if (o_point_z !== want.z) flag_mismatch("z", o_point_z, want.z);
                if (o_found !== want.found)
                    flag_mismatch("found", 32'(o_found), 32'(want.found));
                if (!want.found) misses_found++;
            end
            points_seen++;
        end
    end

    // drive the next beat on the falling edge
    always @(negedge i_clk) begin
        logic    next_start;
        int      idle_pct;
        t_triple t;
        next_start = start;
        if (i_rst_n && (!start || took)) begin
            next_start = 1'b0;
            idle_pct = (beats_sent < total_beats / 3) ? 16 :
                       (beats_sent < 2 * total_beats / 3) ? 77 : 0;
            if (pending_triples.size() != 0 && $urandom_range(99) >= idle_pct) begin
                t = pending_triples[0];
                // hold off until the pipe has drained
                if (!t.drain || expected_points.size() == 0) begin
                    void'(pending_triples.pop_front());
                    drv_a <= t.a;
                    drv_b <= t.b;
                    drv_c <= t.c;
                    next_start = 1'b1;
                    beats_sent++;
                end
            end
        end
        start <= next_start;
    end

    function automatic t_plane mk(int nx, int ny, int nz, int w);
        t_plane p;
        p.nx = nx; p.ny = ny; p.nz = nz; p.w = w;
        return p;
    endfunction

    function automatic t_plane rand_plane(int mode);
        t_plane p;
        if (mode == 0) begin
            p = {$urandom, $urandom, $urandom, $urandom};
        end else begin
            p.nx = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
            p.ny = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
            p.nz = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
            p.w  = $urandom;
        end
        return p;
    endfunction

    task automatic queue_triple(t_plane a, t_plane b, t_plane c, logic drain);
        t_triple t;
        t.a = a; t.b = b; t.c = c; t.drain = drain;
        pending_triples.push_back(t);
    endtask

    initial begin
        int     kind, scale;
        t_plane a, b, c;
        start <= 1'b0;
        drv_a <= '0; drv_b <= '0; drv_c <= '0;
        took <= 1'b0;
        beats_sent = 0; points_seen = 0; misses_found = 0; mismatches = 0;
        stim_done = 1'b0;

        // directed: identity axes, zero, extremes, saturation, degenerate sets
        queue_triple(mk(32'h10000, 0, 0, -32'h10000), mk(0, 32'h10000, 0, -32'h20000),
                     mk(0, 0, 32'h10000, 32'h30000), 1'b0);
        queue_triple(mk(0, 0, 0, 0), mk(0, 0, 0, 0), mk(0, 0, 0, 0), 1'b0);
        queue_triple(mk(32'h80000000, 0, 0, 32'h80000000),
                     mk(0, 32'h80000000, 0, 32'h80000000),
                     mk(0, 0, 32'h80000000, 32'h80000000), 1'b0);
        queue_triple(mk(32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF),
                     mk(0, 32'h7FFFFFFF, 0, 32'h80000000),
                     mk(0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF), 1'b0);
        queue_triple(mk(1, 0, 0, 32'h80000000), mk(0, 1, 0, 32'h7FFFFFFF),
                     mk(0, 0, 1, 32'h80000000), 1'b0);
        queue_triple(mk(1, 0, 0, 32'h7FFFFFFF), mk(0, -1, 0, 32'h7FFFFFFF),
                     mk(0, 0, 1, -1), 1'b0);
        queue_triple(mk(32'h10000, 32'h10000, 0, 5), mk(32'h20000, 32'h20000, 0, 7),
                     mk(0, 0, 32'h10000, 9), 1'b0);
        queue_triple(mk(32'h10000, 0, 0, 1), mk(0, 32'h10000, 0, 2),
                     mk(32'h10000, 32'h10000, 0, 3), 1'b0);
        queue_triple(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF),
                     mk(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000),
                     mk(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 1'b0);
        queue_triple(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, -1),
                     mk(-1, -1, -1, -1), mk(-1, 32'h7FFFFFFF, 1, 32'h80000000), 1'b0);
        queue_triple(mk(-1, -1, -1, -1), mk(-1, -1, -1, -1), mk(-1, -1, -1, -1), 1'b0);
        queue_triple(mk(3, 1, 2, 32'h12345), mk(1, 3, 2, -32'h5432),
                     mk(2, 1, 3, 32'h1111), 1'b0);

        total_beats = 12 + N_RANDOM;
        for (int i = 0; i < N_RANDOM; i++) begin
            kind = $urandom_range(9);
            a = rand_plane(kind < 3 ? 0 : 1);
            b = rand_plane(kind < 3 ? 0 : 1);
            c = rand_plane(kind < 3 ? 0 : 1);
            if (kind == 9) begin
                // parallel pair of normals
                scale = $urandom_range(3) + 1;
                b.nx = a.nx * scale; b.ny = a.ny * scale; b.nz = a.nz * scale;
            end else if (kind == 8) begin
                // coplanar normals: third is the sum of the first two
                c.nx = a.nx + b.nx; c.ny = a.ny + b.ny; c.nz = a.nz + b.nz;
            end
            queue_triple(a, b, c, i == N_RANDOM / 2);
        end

        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_triples.size() == 0);
        @(negedge i_clk);
        wait (!start);
        wait (expected_points.size() == 0);
        repeat (300) @(posedge i_clk);

        $display("covered %0d plane triples, %0d result beats, %0d without an intersection",
                 beats_sent, points_seen, misses_found);
        $display("sender idle mixes of 16, 77 and 0 percent, one full drain mid-run");
        if (mismatches == 0 && expected_points.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
